/* rtl/dnsmsc_pkg.sv */
// ----------------------------------------------------------------------------
// DNS message structure checker package
// Result word type and the fixed constants of the DNS wire format.
// ----------------------------------------------------------------------------
package dnsmsc_pkg;

   localparam int COUNT_W     = 16;
   localparam int DEPTH_W     = 7;
   localparam int BYTE_W      = 8;
   localparam int ITEMS_W     = 7;
   localparam int PTR_W       = 14;

   localparam int HEADER_BYTES     = 12;
   localparam int COUNTS_FIRST     = 4;
   localparam int QUESTION_LIMIT   = 16;
   localparam int RECORD_LIMIT     = 64;
   localparam int QUESTION_FIXED   = 4;
   localparam int RECORD_FIXED     = 10;

   localparam logic [1:0] LABEL_TYPE_MASK_HI = 2'b11;
   localparam logic [1:0] LABEL_TYPE_PLAIN   = 2'b00;

   localparam logic [1:0] SEC_QUESTION   = 2'd0;
   localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

   typedef struct packed {
      logic               verdict;
      logic [COUNT_W-1:0] questions;
      logic [COUNT_W-1:0] answers;
      logic [COUNT_W-1:0] authorities;
      logic [COUNT_W-1:0] additionals;
      logic               malformed_flag;
      logic               pointer_seen;
      logic               loop_risk;
      logic               trailing_data;
      logic [DEPTH_W-1:0] max_depth;
   } rsp_word_type;

endpackage

/* rtl/dns_message_structure_checker.sv */
// ----------------------------------------------------------------------------
// DNS message structure checker
// Byte-wide DNS message walker with one summary word per message.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle on req_ and returns one summary word on
// rsp_ for the byte marked final. Each byte passes through an input register,
// a single pass of walker logic and, on the final byte, a result register;
// a byte can be accepted in every cycle, and a final byte moves on as soon
// as the result register is free or being emptied. Its summary is written
// to the result register as it leaves the input register; while an earlier
// summary waits to be taken, the final byte holds there and req_ stalls.
module dns_message_structure_checker import dnsmsc_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 4096,
   parameter int MAX_NAME_STEPS    = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_message_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_verdict,
   output logic [COUNT_W-1:0] rsp_questions,
   output logic [COUNT_W-1:0] rsp_answers,
   output logic [COUNT_W-1:0] rsp_authorities,
   output logic [COUNT_W-1:0] rsp_additionals,
   output logic               rsp_malformed_flag,
   output logic               rsp_pointer_seen,
   output logic               rsp_loop_risk,
   output logic               rsp_trailing_data,
   output logic [DEPTH_W-1:0] rsp_max_depth
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      summary;
   logic              advance;
   logic              rsp_free;

   dnsmsc_walker #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
      .MAX_NAME_STEPS    (MAX_NAME_STEPS)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .msg_byte (in_byte_ff),
      .last     (in_last_ff),
      .summary  (summary)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_message_byte;
         in_last_ff <= req_final_byte;
      end
      if (advance && in_last_ff) begin
         rsp_word_ff <= summary;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_word_ff.verdict;
   assign rsp_questions      = rsp_word_ff.questions;
   assign rsp_answers        = rsp_word_ff.answers;
   assign rsp_authorities    = rsp_word_ff.authorities;
   assign rsp_additionals    = rsp_word_ff.additionals;
   assign rsp_malformed_flag = rsp_word_ff.malformed_flag;
   assign rsp_pointer_seen   = rsp_word_ff.pointer_seen;
   assign rsp_loop_risk      = rsp_word_ff.loop_risk;
   assign rsp_trailing_data  = rsp_word_ff.trailing_data;
   assign rsp_max_depth      = rsp_word_ff.max_depth;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_last_ff && rsp_valid_ff)
      else $error("input stalled without a waiting final word");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict |-> rsp_questions == '0 && rsp_answers == '0 &&
         rsp_authorities == '0 && rsp_additionals == '0 && !rsp_malformed_flag &&
         !rsp_pointer_seen && !rsp_loop_risk && !rsp_trailing_data &&
         rsp_max_depth == '0)
      else $error("length rejection carries summary fields");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_max_depth) <= MAX_NAME_STEPS)
      else $error("reported name depth beyond the step limit");

endmodule

/* rtl/dnsmsc_walker.sv */
// ----------------------------------------------------------------------------
// DNS message walker
// Per-byte state update: header counts, name, fixed and rdata walk, summary.
// ----------------------------------------------------------------------------
module dnsmsc_walker import dnsmsc_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 4096,
   parameter int MAX_NAME_STEPS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] msg_byte,
   input  logic              last,
   output rsp_word_type      summary
);

   localparam int POS_W  = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int STEP_W = $clog2(MAX_NAME_STEPS + 2);
   localparam int CMP_W  = (POS_W > PTR_W) ? POS_W : PTR_W;

   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_NAME     = 3'd1;
   localparam logic [2:0] PH_PTR2     = 3'd2;
   localparam logic [2:0] PH_LABEL    = 3'd3;
   localparam logic [2:0] PH_FIXED    = 3'd4;
   localparam logic [2:0] PH_RDATA    = 3'd5;
   localparam logic [2:0] PH_COMPLETE = 3'd6;
   localparam logic [2:0] PH_STOPPED  = 3'd7;

   logic [POS_W-1:0]                pos_ff, pos_in;
   logic                            oversize_ff, oversize_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [1:0]                      sec_ff, sec_in;
   logic [ITEMS_W-1:0]              items_ff, items_in;
   logic [COUNT_W-1:0]              left_ff, left_in;
   logic [BYTE_W-1:0]               rdhigh_ff, rdhigh_in;
   logic [PTR_W-BYTE_W-1:0]         ptrhigh_ff, ptrhigh_in;
   logic [POS_W-1:0]                origin_ff, origin_in;
   logic [STEP_W-1:0]               steps_ff, steps_in;
   logic [3:0][COUNT_W-1:0]         counts_ff, counts_in;
   logic                            malformed_ff, malformed_in;
   logic                            pointer_ff, pointer_in;
   logic                            loop_ff, loop_in;
   logic                            trailing_ff, trailing_in;
   logic [STEP_W-1:0]               deepest_ff, deepest_in;

   logic                            do_seek;
   logic [1:0]                      seek_sec;
   logic [ITEMS_W-1:0]              seek_items;
   logic                            found;
   logic [3:0]                      hdr_off;
   logic [STEP_W-1:0]               steps_next;
   logic [COUNT_W-1:0]              left_dec;
   logic [COUNT_W-1:0]              rdlength;
   logic [CMP_W-1:0]                ptr_target;
   logic [CMP_W-1:0]                ptr_origin;
   logic                            over_limit;
   logic                            reject;
   logic                            open_walk;

   always_comb begin
      pos_in       = pos_ff;
      oversize_in  = oversize_ff;
      phase_in     = phase_ff;
      sec_in       = sec_ff;
      items_in     = items_ff;
      left_in      = left_ff;
      rdhigh_in    = rdhigh_ff;
      ptrhigh_in   = ptrhigh_ff;
      origin_in    = origin_ff;
      steps_in     = steps_ff;
      counts_in    = counts_ff;
      malformed_in = malformed_ff;
      pointer_in   = pointer_ff;
      loop_in      = loop_ff;
      trailing_in  = trailing_ff;
      deepest_in   = deepest_ff;
      do_seek      = 1'b0;
      seek_sec     = sec_ff;
      seek_items   = items_ff;
      found        = 1'b0;
      hdr_off      = pos_ff[3:0] - 4'(COUNTS_FIRST);
      steps_next   = steps_ff + STEP_W'(1);
      left_dec     = (left_ff != '0) ? left_ff - COUNT_W'(1) : left_ff;
      rdlength     = {rdhigh_ff, msg_byte};
      ptr_target   = CMP_W'({ptrhigh_ff, msg_byte});
      ptr_origin   = CMP_W'(origin_ff);
      over_limit   = 1'b0;

      if (pos_ff >= POS_W'(MAX_MESSAGE_BYTES)) begin
         oversize_in = 1'b1;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff >= POS_W'(COUNTS_FIRST) && pos_ff < POS_W'(HEADER_BYTES)) begin
               if (!pos_ff[0]) begin
                  counts_in[hdr_off[2:1]] = {msg_byte, BYTE_W'(0)};
               end else begin
                  counts_in[hdr_off[2:1]] = {counts_ff[hdr_off[2:1]][COUNT_W-1:BYTE_W],
                                             msg_byte};
               end
            end
            if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
               over_limit = counts_in[0] > COUNT_W'(QUESTION_LIMIT) ||
                            counts_in[1] > COUNT_W'(RECORD_LIMIT) ||
                            counts_in[2] > COUNT_W'(RECORD_LIMIT) ||
                            counts_in[3] > COUNT_W'(RECORD_LIMIT);
               if (over_limit) begin
                  malformed_in = 1'b1;
                  phase_in     = PH_STOPPED;
               end else begin
                  do_seek    = 1'b1;
                  seek_sec   = SEC_QUESTION;
                  seek_items = counts_in[0][ITEMS_W-1:0];
               end
            end
         end
         PH_NAME: begin
            steps_in = steps_next;
            if (steps_next > STEP_W'(MAX_NAME_STEPS)) begin
               loop_in  = 1'b1;
               phase_in = PH_STOPPED;
            end else begin
               if (steps_next > deepest_ff) begin
                  deepest_in = steps_next;
               end
               if (msg_byte[7:6] == LABEL_TYPE_MASK_HI) begin
                  ptrhigh_in = msg_byte[5:0];
                  origin_in  = pos_ff;
                  phase_in   = PH_PTR2;
               end else if (msg_byte[7:6] != LABEL_TYPE_PLAIN) begin
                  malformed_in = 1'b1;
                  phase_in     = PH_STOPPED;
               end else if (msg_byte == '0) begin
                  phase_in = PH_FIXED;
                  left_in  = (sec_ff == SEC_QUESTION) ? COUNT_W'(QUESTION_FIXED)
                                                      : COUNT_W'(RECORD_FIXED);
               end else begin
                  left_in  = COUNT_W'(msg_byte);
                  phase_in = PH_LABEL;
               end
            end
         end
         PH_PTR2: begin
            pointer_in = 1'b1;
            if (ptr_target >= ptr_origin) begin
               loop_in  = 1'b1;
               phase_in = PH_STOPPED;
            end else begin
               phase_in = PH_FIXED;
               left_in  = (sec_ff == SEC_QUESTION) ? COUNT_W'(QUESTION_FIXED)
                                                   : COUNT_W'(RECORD_FIXED);
            end
         end
         PH_LABEL: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_NAME;
            end
         end
         PH_FIXED: begin
            if (sec_ff != SEC_QUESTION && left_ff == COUNT_W'(2)) begin
               rdhigh_in = msg_byte;
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               rdhigh_in = '0;
               if (sec_ff != SEC_QUESTION && rdlength != '0) begin
                  left_in  = rdlength;
                  phase_in = PH_RDATA;
               end else begin
                  do_seek    = 1'b1;
                  seek_items = (items_ff != '0) ? items_ff - ITEMS_W'(1) : items_ff;
               end
            end
         end
         PH_RDATA: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               do_seek    = 1'b1;
               seek_items = (items_ff != '0) ? items_ff - ITEMS_W'(1) : items_ff;
            end
         end
         PH_COMPLETE: begin
            trailing_in = 1'b1;
         end
         default: begin
         end
      endcase

      // advance to the next item, skipping empty sections
      if (do_seek) begin
         if (seek_items != '0) begin
            phase_in = PH_NAME;
            sec_in   = seek_sec;
            items_in = seek_items;
            steps_in = '0;
         end else begin
            for (int j = 1; j < 4; j++) begin
               if (!found && 2'(j) > seek_sec && counts_in[j] != '0) begin
                  found    = 1'b1;
                  sec_in   = 2'(j);
                  items_in = counts_in[j][ITEMS_W-1:0];
               end
            end
            if (found) begin
               phase_in = PH_NAME;
               steps_in = '0;
            end else begin
               phase_in = PH_COMPLETE;
               sec_in   = SEC_ADDITIONAL;
               items_in = '0;
            end
         end
      end
   end

   always_comb begin
      reject    = oversize_in || pos_ff < POS_W'(HEADER_BYTES - 1);
      open_walk = phase_in != PH_COMPLETE && phase_in != PH_STOPPED;
      summary   = '0;
      if (reject) begin
         summary.verdict = 1'b1;
      end else begin
         summary.questions      = counts_in[0];
         summary.answers        = counts_in[1];
         summary.authorities    = counts_in[2];
         summary.additionals    = counts_in[3];
         summary.malformed_flag = malformed_in || open_walk;
         summary.pointer_seen   = pointer_in;
         summary.loop_risk      = loop_in;
         summary.trailing_data  = phase_in == PH_COMPLETE && trailing_in;
         summary.max_depth      = DEPTH_W'(deepest_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         pos_ff       <= '0;
         oversize_ff  <= 1'b0;
         phase_ff     <= PH_HEADER;
         sec_ff       <= SEC_QUESTION;
         items_ff     <= '0;
         left_ff      <= '0;
         rdhigh_ff    <= '0;
         ptrhigh_ff   <= '0;
         origin_ff    <= '0;
         steps_ff     <= '0;
         counts_ff    <= '0;
         malformed_ff <= 1'b0;
         pointer_ff   <= 1'b0;
         loop_ff      <= 1'b0;
         trailing_ff  <= 1'b0;
         deepest_ff   <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         oversize_ff  <= oversize_in;
         phase_ff     <= phase_in;
         sec_ff       <= sec_in;
         items_ff     <= items_in;
         left_ff      <= left_in;
         rdhigh_ff    <= rdhigh_in;
         ptrhigh_ff   <= ptrhigh_in;
         origin_ff    <= origin_in;
         steps_ff     <= steps_in;
         counts_ff    <= counts_in;
         malformed_ff <= malformed_in;
         pointer_ff   <= pointer_in;
         loop_ff      <= loop_in;
         trailing_ff  <= trailing_in;
         deepest_ff   <= deepest_in;
      end
   end

   a_header_position: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> pos_ff >= POS_W'(HEADER_BYTES))
      else $error("walk left the header before byte twelve");

   a_name_steps: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NAME |-> steps_ff <= STEP_W'(MAX_NAME_STEPS))
      else $error("name step count passed its limit inside a name");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && last |=> phase_ff == PH_HEADER && pos_ff == '0)
      else $error("walker did not restart after the last byte");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS message structure checker testbench
// Streams DNS messages into the checker one byte per word, with random
// gaps on the sender and random stalls on the summary side. A behavioural
// walker in the bench predicts each summary word, and a checker process
// compares every returned word against the oldest prediction. Directed
// messages cover length bounds, count limits, name and pointer rules and
// truncation. Random messages follow, mostly well formed with some cut
// short, padded, corrupted or replaced by noise.
// ----------------------------------------------------------------------------
module testbench import dnsmsc_pkg::*; ();

   localparam int MSG_LIMIT       = 4096;
   localparam int STEP_LIMIT      = 64;
   localparam int SUMMARY_LATENCY = 2;

   typedef enum logic [2:0] {
      W_HEADER, W_NAME, W_PTR_LOW, W_LABEL, W_FIXED, W_RDATA, W_DONE, W_HALTED
   } walk_phase_type;

   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PATTERN} drain_mode_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_message_byte = '0;
   logic               req_final_byte   = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic               rsp_verdict;
   logic [COUNT_W-1:0] rsp_questions;
   logic [COUNT_W-1:0] rsp_answers;
   logic [COUNT_W-1:0] rsp_authorities;
   logic [COUNT_W-1:0] rsp_additionals;
   logic               rsp_malformed_flag;
   logic               rsp_pointer_seen;
   logic               rsp_loop_risk;
   logic               rsp_trailing_data;
   logic [DEPTH_W-1:0] rsp_max_depth;

   dns_message_structure_checker #(
      .MAX_MESSAGE_BYTES(MSG_LIMIT),
      .MAX_NAME_STEPS   (STEP_LIMIT)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_message_byte  (req_message_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_questions     (rsp_questions),
      .rsp_answers       (rsp_answers),
      .rsp_authorities   (rsp_authorities),
      .rsp_additionals   (rsp_additionals),
      .rsp_malformed_flag(rsp_malformed_flag),
      .rsp_pointer_seen  (rsp_pointer_seen),
      .rsp_loop_risk     (rsp_loop_risk),
      .rsp_trailing_data (rsp_trailing_data),
      .rsp_max_depth     (rsp_max_depth)
   );

   // walker state of the predictor
   logic [12:0]        byte_count;
   logic               past_limit;
   walk_phase_type     walk;
   logic [1:0]         section;
   logic [15:0]        pending_items;
   logic [15:0]        pending_bytes;
   logic [15:0]        rdlength;
   logic [5:0]         ptr_hi;
   logic [12:0]        ptr_at;
   logic [6:0]         steps;
   logic [COUNT_W-1:0] counts [4];
   logic               seen_malformed;
   logic               seen_pointer;
   logic               seen_loop;
   logic               seen_trailing;
   logic [DEPTH_W-1:0] deepest;

   rsp_word_type       expected_summaries[$];
   rsp_word_type       got_summary;
   rsp_word_type       want_summary;
   logic [7:0]         msg[$];
   int unsigned        failures   = 0;
   int unsigned        bytes_sent = 0;
   int unsigned        burst_left = 0;
   drain_mode_type     drain_mode = DRAIN_FREE;
   int unsigned        drain_left = 0;
   logic [31:0]        drain_bits = 32'h1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

   task automatic clear_walk();
      byte_count     = '0;
      past_limit     = 1'b0;
      walk           = W_HEADER;
      section        = SEC_QUESTION;
      pending_items  = '0;
      pending_bytes  = '0;
      rdlength       = '0;
      ptr_hi         = '0;
      ptr_at         = '0;
      steps          = '0;
      foreach (counts[i]) counts[i] = '0;
      seen_malformed = 1'b0;
      seen_pointer   = 1'b0;
      seen_loop      = 1'b0;
      seen_trailing  = 1'b0;
      deepest        = '0;
   endtask

   task automatic next_entry();
      while (pending_items == 0 && section != SEC_ADDITIONAL) begin
         section       = section + 2'd1;
         pending_items = counts[section];
      end
      if (pending_items == 0) begin
         walk = W_DONE;
      end else begin
         walk  = W_NAME;
         steps = '0;
      end
   endtask

   task automatic close_entry();
      if (pending_items != 0) pending_items = pending_items - 16'd1;
      next_entry();
   endtask

   task automatic end_of_name();
      walk          = W_FIXED;
      pending_bytes = (section == SEC_QUESTION) ? 16'(QUESTION_FIXED) : 16'(RECORD_FIXED);
   endtask

   task automatic parse_byte(input logic [7:0] value, input logic last);
      int           idx;
      int           k;
      rsp_word_type s;
      idx = byte_count;
      if (idx >= MSG_LIMIT) past_limit = 1'b1;
      else byte_count = 13'(idx + 1);

      case (walk)
         W_HEADER: begin
            if (idx >= COUNTS_FIRST && idx < HEADER_BYTES) begin
               k = (idx - COUNTS_FIRST) >> 1;
               if (idx % 2 == 0) counts[k] = {value, 8'h00};
               else counts[k][7:0] = value;
            end
            if (idx == HEADER_BYTES - 1) begin
               if (counts[0] > QUESTION_LIMIT || counts[1] > RECORD_LIMIT ||
                   counts[2] > RECORD_LIMIT || counts[3] > RECORD_LIMIT) begin
                  seen_malformed = 1'b1;
                  walk           = W_HALTED;
               end else begin
                  section       = SEC_QUESTION;
                  pending_items = counts[0];
                  next_entry();
               end
            end
         end
         W_NAME: begin
            steps = steps + 7'd1;
            if (steps > STEP_LIMIT) begin
               seen_loop = 1'b1;
               walk      = W_HALTED;
            end else begin
               if (steps > deepest) deepest = steps;
               if (value[7:6] == LABEL_TYPE_MASK_HI) begin
                  ptr_hi = value[5:0];
                  ptr_at = 13'(idx);
                  walk   = W_PTR_LOW;
               end else if (value[7:6] != LABEL_TYPE_PLAIN) begin
                  seen_malformed = 1'b1;
                  walk           = W_HALTED;
               end else if (value == 8'h00) begin
                  end_of_name();
               end else begin
                  pending_bytes = {8'h00, value};
                  walk          = W_LABEL;
               end
            end
         end
         W_PTR_LOW: begin
            seen_pointer = 1'b1;
            if ({ptr_hi, value} >= {1'b0, ptr_at}) begin
               seen_loop = 1'b1;
               walk      = W_HALTED;
            end else begin
               end_of_name();
            end
         end
         W_LABEL: begin
            if (pending_bytes != 0) pending_bytes = pending_bytes - 16'd1;
            if (pending_bytes == 0) walk = W_NAME;
         end
         W_FIXED: begin
            if (section != SEC_QUESTION) begin
               if (pending_bytes == 2) rdlength = {8'h00, value};
               else if (pending_bytes == 1) rdlength = {rdlength[7:0], value};
            end
            if (pending_bytes != 0) pending_bytes = pending_bytes - 16'd1;
            if (pending_bytes == 0) begin
               if (section != SEC_QUESTION && rdlength != 0) begin
                  pending_bytes = rdlength;
                  rdlength      = '0;
                  walk          = W_RDATA;
               end else begin
                  rdlength = '0;
                  close_entry();
               end
            end
         end
         W_RDATA: begin
            if (pending_bytes != 0) pending_bytes = pending_bytes - 16'd1;
            if (pending_bytes == 0) close_entry();
         end
         W_DONE: seen_trailing = 1'b1;
         default: ;
      endcase

      if (last) begin
         s = '0;
         if (past_limit || idx < HEADER_BYTES - 1) begin
            s.verdict = 1'b1;
         end else begin
            s.questions      = counts[0];
            s.answers        = counts[1];
            s.authorities    = counts[2];
            s.additionals    = counts[3];
            s.malformed_flag = seen_malformed || (walk != W_DONE && walk != W_HALTED);
            s.pointer_seen   = seen_pointer;
            s.loop_risk      = seen_loop;
            s.trailing_data  = (walk == W_DONE) && seen_trailing;
            s.max_depth      = deepest;
         end
         expected_summaries.push_back(s);
         clear_walk();
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      int pause;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (pause != 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_message_byte <= value;
      req_final_byte   <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      parse_byte(value, last);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
      msg.delete();
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (SUMMARY_LATENCY + 2) @(posedge clock);
   endtask

   task automatic add_header(input int qd, input int an, input int ns, input int ar);
      int tally[4];
      tally = '{qd, an, ns, ar};
      repeat (COUNTS_FIRST) msg.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) begin
         msg.push_back(8'(tally[i] >> 8));
         msg.push_back(8'(tally[i]));
      end
   endtask

   task automatic add_label(input int len);
      msg.push_back(8'(len));
      repeat (len) msg.push_back(8'($urandom));
   endtask

   task automatic add_pointer(input int target);
      msg.push_back({2'b11, 6'(target >> 8)});
      msg.push_back(8'(target));
   endtask

   task automatic add_fixed(input logic is_record, input int rdlen);
      if (is_record) begin
         repeat (RECORD_FIXED - 2) msg.push_back(8'($urandom));
         msg.push_back(8'(rdlen >> 8));
         msg.push_back(8'(rdlen));
         repeat (rdlen) msg.push_back(8'($urandom));
      end else begin
         repeat (QUESTION_FIXED) msg.push_back(8'($urandom));
      end
   endtask

   task automatic test_length_limits();
      msg.push_back(8'($urandom));
      send_message();
      repeat (HEADER_BYTES - 1) msg.push_back(8'($urandom));
      send_message();
      add_header(0, 0, 0, 0);
      send_message();
      add_header(0, 0, 0, 0);
      while (msg.size() < MSG_LIMIT) msg.push_back(8'($urandom));
      send_message();
      // run past the limit so the byte counter saturates
      add_header(0, 0, 0, 0);
      while (msg.size() < MSG_LIMIT + 200) msg.push_back(8'($urandom));
      send_message();
      settle();
   endtask

   task automatic test_count_limits();
      add_header(QUESTION_LIMIT, 0, 0, 0);
      repeat (QUESTION_LIMIT) begin
         add_label(2);
         msg.push_back(8'h00);
         add_fixed(1'b0, 0);
      end
      send_message();
      add_header(QUESTION_LIMIT + 1, 0, 0, 0);
      repeat (8) msg.push_back(8'($urandom));
      send_message();
      add_header(0, RECORD_LIMIT + 1, 0, 0);
      send_message();
      add_header(0, 0, RECORD_LIMIT + 1, 0);
      repeat (3) msg.push_back(8'($urandom));
      send_message();
      add_header(0, 0, 0, RECORD_LIMIT + 1);
      send_message();
      add_header(0, 0, 0, RECORD_LIMIT);
      repeat (RECORD_LIMIT) begin
         add_pointer(HEADER_BYTES);
         add_fixed(1'b1, 0);
      end
      send_message();
      add_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_message();
      settle();
   endtask

   task automatic test_names();
      add_header(2, 2, 1, 1);
      add_label(3);
      add_label(5);
      msg.push_back(8'h00);
      add_fixed(1'b0, 0);
      add_label(2);
      add_pointer(HEADER_BYTES);
      add_fixed(1'b0, 0);
      add_pointer(HEADER_BYTES);
      add_fixed(1'b1, 4);
      add_label(63);
      msg.push_back(8'h00);
      add_fixed(1'b1, 300);
      msg.push_back(8'h00);
      add_fixed(1'b1, 0);
      add_pointer(msg.size() - 1);
      add_fixed(1'b1, 1);
      send_message();

      add_header(1, 0, 0, 0);
      add_pointer(msg.size() + 5);
      add_fixed(1'b0, 0);
      send_message();
      add_header(1, 0, 0, 0);
      add_label(1);
      add_pointer(msg.size());
      add_fixed(1'b0, 0);
      send_message();
      add_header(0, 1, 0, 0);
      add_pointer(16'h3FFF);
      add_fixed(1'b1, 0);
      send_message();

      add_header(1, 0, 0, 0);
      add_label(2);
      msg.push_back(8'h40);
      repeat (6) msg.push_back(8'($urandom));
      send_message();
      add_header(1, 0, 0, 0);
      msg.push_back(8'hBF);
      repeat (4) msg.push_back(8'($urandom));
      send_message();

      add_header(1, 0, 0, 0);
      repeat (STEP_LIMIT - 1) add_label(1);
      msg.push_back(8'h00);
      add_fixed(1'b0, 0);
      send_message();
      add_header(1, 0, 0, 0);
      repeat (STEP_LIMIT) add_label(1);
      msg.push_back(8'h00);
      add_fixed(1'b0, 0);
      send_message();
      add_header(1, 0, 0, 0);
      repeat (STEP_LIMIT) add_label(1);
      add_pointer(HEADER_BYTES);
      add_fixed(1'b0, 0);
      send_message();
      settle();
   endtask

   task automatic test_truncation();
      add_header(1, 0, 0, 0);
      msg.push_back(8'd5);
      repeat (2) msg.push_back(8'($urandom));
      send_message();
      add_header(1, 0, 0, 0);
      add_label(1);
      msg.push_back(8'h00);
      repeat (2) msg.push_back(8'($urandom));
      send_message();
      add_header(0, 1, 0, 0);
      msg.push_back(8'h00);
      add_fixed(1'b1, 8);
      repeat (5) void'(msg.pop_back());
      send_message();
      // end on the first byte of a pointer
      add_header(1, 0, 0, 0);
      msg.push_back(8'hC0);
      send_message();
      add_header(0, 0, 0, 1);
      send_message();
      add_header(1, 0, 0, 0);
      add_label(4);
      msg.push_back(8'h00);
      add_fixed(1'b0, 0);
      repeat (3) msg.push_back(8'($urandom));
      send_message();
      settle();
   endtask

   task automatic test_random_messages();
      int          kind;
      int          pick;
      int          sent_msgs;
      int          qd;
      int          an;
      int          ns;
      int          ar;
      int unsigned start_bytes;
      sent_msgs   = 0;
      start_bytes = bytes_sent;
      while (sent_msgs < 60 || bytes_sent - start_bytes < 500) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom));
         end else begin
            qd = $urandom_range(0, 3);
            an = $urandom_range(0, 3);
            ns = $urandom_range(0, 2);
            ar = $urandom_range(0, 2);
            if ($urandom_range(0, 19) == 0) qd = $urandom_range(0, QUESTION_LIMIT + 1);
            add_header(qd, an, ns, ar);
            for (int e = 0; e < qd + an + ns + ar && e < QUESTION_LIMIT + 8; e++) begin
               repeat ($urandom_range(0, 3)) add_label($urandom_range(1, 6));
               pick = $urandom_range(0, 19);
               if (pick < 13) msg.push_back(8'h00);
               else if (pick < 19) add_pointer($urandom_range(0, msg.size() - 1));
               else add_pointer(msg.size() + $urandom_range(0, 2));
               add_fixed(e >= qd, $urandom_range(0, 6));
            end
            if (kind == 6) begin
               repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            end else if (kind == 7) begin
               repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom));
            end else if (kind == 8) begin
               msg[$urandom_range(COUNTS_FIRST, msg.size() - 1)] = 8'($urandom);
            end
         end
         send_message();
         sent_msgs++;
      end
      settle();
   endtask

   function automatic string show_summary(rsp_word_type s);
      return $sformatf({"verdict=%0d qd=%0d an=%0d ns=%0d ar=%0d ",
                        "mal=%0d ptr=%0d loop=%0d trail=%0d depth=%0d"},
                       s.verdict, s.questions, s.answers, s.authorities, s.additionals,
                       s.malformed_flag, s.pointer_seen, s.loop_risk, s.trailing_data,
                       s.max_depth);
   endfunction

   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 2));
         drain_left = $urandom_range(16, 160);
         drain_bits = $urandom | 32'h1;
      end else begin
         drain_left--;
      end
      case (drain_mode)
         DRAIN_FREE: rsp_ready <= 1'b1;
         DRAIN_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: begin
            rsp_ready  <= drain_bits[0];
            drain_bits = {drain_bits[0], drain_bits[31:1]};
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_summary = {rsp_verdict, rsp_questions, rsp_answers, rsp_authorities,
                        rsp_additionals, rsp_malformed_flag, rsp_pointer_seen,
                        rsp_loop_risk, rsp_trailing_data, rsp_max_depth};
         if (expected_summaries.size() == 0) begin
            if (failures < 10) $display("unexpected summary %s", show_summary(got_summary));
            failures++;
         end else begin
            want_summary = expected_summaries.pop_front();
            if (got_summary !== want_summary) begin
               if (failures < 10) begin
                  $display("summary mismatch, expected %s", show_summary(want_summary));
                  $display("                  actual   %s", show_summary(got_summary));
               end
               failures++;
            end
         end
      end
   end

   initial begin
      clear_walk();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_length_limits();
      test_count_limits();
      test_names();
      test_truncation();
      test_random_messages();
      if (failures == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
